FILE: design/mct_pkg.sv
// Shared types and constants for the memory-mapped console terminal.
`default_nettype none
package mct_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int WORD_WIDTH      = 32;
    localparam int BYTE_WIDTH      = 8;

    localparam logic [CFG_DATA_WIDTH-1:0] RECV_HOLD_RESET  = 16'd100;
    localparam logic [CFG_DATA_WIDTH-1:0] TRANS_BUSY_RESET = 16'd100;

    localparam logic [BYTE_WIDTH-1:0] BYTE_MASK = 8'hff;

    localparam int READY_BIT  = 0;
    localparam int ENABLE_BIT = 1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_RX_CTRL = 2'd0,
        REG_RX_DATA = 2'd1,
        REG_TX_CTRL = 2'd2,
        REG_TX_DATA = 2'd3
    } reg_sel_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_RECV_HOLD  = 1'd0,
        CFG_TRANS_BUSY = 1'd1
    } cfg_sel_t;

endpackage
`default_nettype wire

FILE: design/mmio_console_terminal.sv
// Memory-mapped console terminal: receiver and transmitter registers with timers.
//
// Usage: each request on the input channel (in_valid/in_ready) is a tick, a
// register read or a register write. Every request yields exactly one result
// on the output channel (out_valid/out_ready), carrying the read byte, the
// receive and transmit character strobes and both interrupt levels.
// A request accepted at one edge is offered as a result from the next
// cycle. Throughput is one request per cycle while results are taken; the
// state update and result are one pass of flag and counter logic into the
// result register. When the receiver stalls, the result register holds its
// value and in_ready drops until it is taken; a result taken in the same
// cycle lets a new request in at once.
// The configuration channel (cfg_valid/cfg_ready) is always ready and loads
// the receiver hold-off and transmitter busy reload values.
// After reset both reload values are 100, the transmitter is ready, the
// receiver is empty, all interrupts are off and no result is pending.
`default_nettype none
module mmio_console_terminal #(
    parameter int TIMER_WIDTH = mct_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mct_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [mct_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          cmd,
    input  wire logic [1:0]                          reg_index,
    input  wire logic [mct_pkg::WORD_WIDTH-1:0]      write_data,
    input  wire logic                                char_offered,
    input  wire logic [mct_pkg::BYTE_WIDTH-1:0]      char_in,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [mct_pkg::BYTE_WIDTH-1:0]           read_data,
    output logic                                     char_taken,
    output logic                                     char_out_valid,
    output logic [mct_pkg::BYTE_WIDTH-1:0]           char_out,
    output logic                                     recv_irq,
    output logic                                     trans_irq
);
    import mct_pkg::*;

    localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);

    logic [TIMER_WIDTH-1:0] recv_hold_reg;
    logic [TIMER_WIDTH-1:0] trans_busy_reg;

    logic                   rx_ready_reg, rx_ready_next;
    logic                   rx_en_reg, rx_en_next;
    logic [BYTE_WIDTH-1:0]  rx_byte_reg, rx_byte_next;
    logic [TIMER_WIDTH-1:0] rx_timer_reg, rx_timer_next;
    logic                   tx_ready_reg, tx_ready_next;
    logic                   tx_en_reg, tx_en_next;
    logic [BYTE_WIDTH-1:0]  tx_byte_reg, tx_byte_next;
    logic [TIMER_WIDTH-1:0] tx_timer_reg, tx_timer_next;
    logic                   rx_irq_reg, rx_irq_next;
    logic                   tx_irq_reg, tx_irq_next;

    logic                   out_valid_reg;
    logic [BYTE_WIDTH-1:0]  rd_reg, rd_next;
    logic                   taken_reg, taken_next;
    logic                   send_reg, send_next;
    logic [BYTE_WIDTH-1:0]  chout_reg, chout_next;

    logic                   accept;
    logic                   wr_en;
    cmd_t                   cmd_sel;
    reg_sel_t               reg_sel;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_sel   = cmd_t'(cmd);
    assign reg_sel   = reg_sel_t'(reg_index);
    assign wr_en     = write_data[ENABLE_BIT];

    always_comb
    begin
        rx_ready_next = rx_ready_reg;
        rx_en_next    = rx_en_reg;
        rx_byte_next  = rx_byte_reg;
        rx_timer_next = rx_timer_reg;
        tx_ready_next = tx_ready_reg;
        tx_en_next    = tx_en_reg;
        tx_byte_next  = tx_byte_reg;
        tx_timer_next = tx_timer_reg;
        rx_irq_next   = rx_irq_reg;
        tx_irq_next   = tx_irq_reg;
        rd_next       = '0;
        taken_next    = 1'b0;
        send_next     = 1'b0;
        chout_next    = '0;

        case (cmd_sel)
            CMD_TICK:
            begin
                if (rx_timer_reg != '0)
                begin
                    rx_timer_next = rx_timer_reg - TIMER_ONE;
                end
                else if (char_offered)
                begin
                    rx_byte_next  = char_in;
                    rx_ready_next = 1'b1;
                    rx_timer_next = recv_hold_reg;
                    taken_next    = 1'b1;
                    if (rx_en_reg)
                    begin
                        rx_irq_next = 1'b1;
                    end
                end
                if (tx_timer_reg != '0)
                begin
                    tx_timer_next = tx_timer_reg - TIMER_ONE;
                end
                else if (!tx_ready_reg)
                begin
                    tx_ready_next = 1'b1;
                    if (tx_en_reg)
                    begin
                        tx_irq_next = 1'b1;
                    end
                end
            end
            CMD_READ:
            begin
                case (reg_sel)
                    REG_RX_CTRL:
                    begin
                        rd_next[READY_BIT]  = rx_ready_reg;
                        rd_next[ENABLE_BIT] = rx_en_reg;
                    end
                    REG_RX_DATA:
                    begin
                        rd_next       = rx_byte_reg;
                        rx_ready_next = 1'b0;
                        rx_timer_next = '0;
                        rx_irq_next   = 1'b0;
                    end
                    REG_TX_CTRL:
                    begin
                        rd_next[READY_BIT]  = tx_ready_reg;
                        rd_next[ENABLE_BIT] = tx_en_reg;
                    end
                    default:
                    begin
                        rd_next = tx_byte_reg;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                case (reg_sel)
                    REG_RX_CTRL:
                    begin
                        rx_en_next = wr_en;
                        // Enabling raises a pending request; disabling drops it.
                        rx_irq_next = wr_en ? (rx_irq_reg || rx_ready_reg) : 1'b0;
                    end
                    REG_RX_DATA:
                    begin
                    end
                    REG_TX_CTRL:
                    begin
                        tx_en_next  = wr_en;
                        tx_irq_next = wr_en ? (tx_irq_reg || tx_ready_reg) : 1'b0;
                    end
                    default:
                    begin
                        // A data write while the transmitter is busy is dropped.
                        if (tx_ready_reg)
                        begin
                            tx_byte_next  = write_data[BYTE_WIDTH-1:0] & BYTE_MASK;
                            chout_next    = write_data[BYTE_WIDTH-1:0];
                            send_next     = 1'b1;
                            tx_ready_next = 1'b0;
                            tx_timer_next = trans_busy_reg;
                            tx_irq_next   = 1'b0;
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_hold_reg  <= TIMER_WIDTH'(RECV_HOLD_RESET);
            trans_busy_reg <= TIMER_WIDTH'(TRANS_BUSY_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_sel_t'(cfg_index))
                CFG_RECV_HOLD:  recv_hold_reg  <= TIMER_WIDTH'(cfg_data);
                CFG_TRANS_BUSY: trans_busy_reg <= TIMER_WIDTH'(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ready_reg <= 1'b0;
            rx_en_reg    <= 1'b0;
            rx_byte_reg  <= '0;
            rx_timer_reg <= '0;
            tx_ready_reg <= 1'b1;
            tx_en_reg    <= 1'b0;
            tx_byte_reg  <= '0;
            tx_timer_reg <= '0;
            rx_irq_reg   <= 1'b0;
            tx_irq_reg   <= 1'b0;
        end
        else if (accept)
        begin
            rx_ready_reg <= rx_ready_next;
            rx_en_reg    <= rx_en_next;
            rx_byte_reg  <= rx_byte_next;
            rx_timer_reg <= rx_timer_next;
            tx_ready_reg <= tx_ready_next;
            tx_en_reg    <= tx_en_next;
            tx_byte_reg  <= tx_byte_next;
            tx_timer_reg <= tx_timer_next;
            rx_irq_reg   <= rx_irq_next;
            tx_irq_reg   <= tx_irq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; interrupt levels come straight from the state registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg    <= rd_next;
            taken_reg <= taken_next;
            send_reg  <= send_next;
            chout_reg <= chout_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = rd_reg;
    assign char_taken     = taken_reg;
    assign char_out_valid = send_reg;
    assign char_out       = chout_reg;
    assign recv_irq       = rx_irq_reg;
    assign trans_irq      = tx_irq_reg;

endmodule
`default_nettype wire
